FILE: rtl/gbd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbd_pkg
// Shared types and fixed widths for the Golomb bitstream decoder.
// ----------------------------------------------------------------------------
package gbd_pkg;

  // Fixed field widths.
  localparam int CODE_W  = 8;
  localparam int DIV_W   = 16;
  localparam int REM_W   = 17;
  localparam int SEEN_W  = 5;
  localparam int CW_W    = 5;
  localparam int VALUE_W = 32;

  // Queue depths.
  localparam int IN_DEPTH  = 4;
  localparam int OUT_DEPTH = 8;

  // Divisor and the values derived from it.
  typedef struct packed {
    logic [DIV_W-1:0] m;     // effective divisor, never zero
    logic [CW_W-1:0]  c;     // remainder width, ceil(log2 m)
    logic [DIV_W-1:0] u;     // 2^c - m
  } gbd_cfg_t;

  // One finished code on its way to the value unit (quotient travels apart).
  typedef struct packed {
    logic [DIV_W-1:0]   m;
    logic [VALUE_W-1:0] r;
    logic               sat;
    logic               last;
  } gbd_code_t;

endpackage : gbd_pkg
`default_nettype wire

FILE: rtl/gbd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbd_front
// Input byte queue and divisor register with its derived code parameters.
// ----------------------------------------------------------------------------
module gbd_front
  import gbd_pkg::*;
#(
  parameter int DIVISOR_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [CODE_W-1:0] code_byte,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [DIV_W-1:0]  divisor,
  output logic                   byte_valid,
  output logic [CODE_W-1:0]      byte_data,
  input  wire logic              byte_take,
  output gbd_cfg_t               cfg
);

  localparam int PTR_W = $clog2(IN_DEPTH);
  localparam int CNT_W = $clog2(IN_DEPTH + 1);
  localparam logic [DIV_W-1:0] DIV_MASK = DIV_W'((17'd1 << DIVISOR_BITS) - 17'd1);
  localparam logic [DIV_W-1:0] DIV_RESET = DIV_W'(4);

  // Masks the raw divisor, maps zero to one, and finds c and u.
  function automatic gbd_cfg_t derive(input logic [DIV_W-1:0] raw);
    gbd_cfg_t         res;
    logic [DIV_W-1:0] mm;
    logic [DIV_W-1:0] mm1;
    logic [REM_W-1:0] pow;
    mm = raw & DIV_MASK;
    if (mm == '0) begin
      mm = DIV_W'(1);
    end
    mm1 = mm - DIV_W'(1);
    res.c = '0;
    for (int i = 0; i < DIV_W; i++) begin
      if (mm1[i]) begin
        res.c = CW_W'(i + 1);
      end
    end
    pow   = REM_W'(1) << res.c;
    res.m = mm;
    res.u = DIV_W'(pow - {1'b0, mm});
    return res;
  endfunction

  logic [CODE_W-1:0] mem [IN_DEPTH];
  logic [PTR_W-1:0]  wptr;
  logic [PTR_W-1:0]  rptr;
  logic [CNT_W-1:0]  count;
  logic              push_acc;
  logic              pop_acc;

  // Configuration is always taken; derived values are stored at the write.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= derive(DIV_RESET);
    end else if (cfg_valid) begin
      cfg <= derive(divisor);
    end
  end

  // Byte queue handshakes.
  assign full       = (count == CNT_W'(IN_DEPTH));
  assign push_acc   = push && !full;
  assign byte_valid = (count != '0);
  assign pop_acc    = byte_take && byte_valid;
  assign byte_data  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push_acc) begin
      mem[wptr] <= code_byte;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push_acc) begin
        wptr <= wptr + PTR_W'(1);
      end
      if (pop_acc) begin
        rptr <= rptr + PTR_W'(1);
      end
      count <= count + CNT_W'(push_acc) - CNT_W'(pop_acc);
    end
  end

endmodule : gbd_front
`default_nettype wire

FILE: rtl/gbd_bit_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbd_bit_decoder
// Walks each byte one bit per cycle, pausing while a code waits for a free
// result slot, through the unary and remainder phases and holds the newest
// finished code until it is known whether it is the last one of its byte.
// ----------------------------------------------------------------------------
module gbd_bit_decoder
  import gbd_pkg::*;
#(
  parameter int QUOTIENT_BITS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     byte_valid,
  input  wire logic [CODE_W-1:0]        byte_data,
  output logic                          byte_take,
  input  wire gbd_cfg_t                 cfg,
  input  wire logic                     credit_ok,
  output logic                          send,
  output logic [QUOTIENT_BITS-1:0]      send_q,
  output gbd_code_t                     send_code
);

  localparam int IDX_W = $clog2(CODE_W);

  // Shift register for the current byte.
  logic              busy;
  logic [CODE_W-1:0] sr;
  logic [IDX_W-1:0]  bit_idx;

  // Decode state.
  logic                     in_rem;
  logic [QUOTIENT_BITS-1:0] q;
  logic                     sat;
  logic [REM_W-1:0]         racc;
  logic [SEEN_W-1:0]        seen;

  // Pending finished code.
  logic                     p_valid;
  logic                     p_closed;
  logic [QUOTIENT_BITS-1:0] p_q;
  gbd_code_t                p_code;

  // Next decode state for the bit at the head of the shift register.
  logic                     b;
  logic                     emit;
  logic [VALUE_W-1:0]       r_new;
  logic                     in_rem_next;
  logic [QUOTIENT_BITS-1:0] q_next;
  logic                     sat_next;
  logic [REM_W-1:0]         racc_next;
  logic [SEEN_W-1:0]        seen_next;
  logic [REM_W-1:0]         racc_sh;
  logic [SEEN_W-1:0]        seen_inc;
  logic                     last_bit;
  logic                     send_needed;
  logic                     step;
  logic                     flush;

  assign b        = sr[CODE_W-1];
  assign last_bit = (bit_idx == '0);
  assign racc_sh  = {racc[REM_W-2:0], b};
  assign seen_inc = seen + SEEN_W'(1);

  // Single-bit decode step.
  always_comb begin
    emit        = 1'b0;
    r_new       = '0;
    in_rem_next = in_rem;
    q_next      = q;
    sat_next    = sat;
    racc_next   = racc;
    seen_next   = seen;
    if (!in_rem) begin
      if (b) begin
        if (q == '1) begin
          sat_next = 1'b1;
        end else begin
          q_next = q + QUOTIENT_BITS'(1);
        end
      end else begin
        in_rem_next = 1'b1;
        racc_next   = '0;
        seen_next   = '0;
        // With no remainder bits the closing zero ends the code.
        emit = (cfg.c == '0);
      end
    end else begin
      racc_next = racc_sh;
      seen_next = seen_inc;
      if (cfg.c == '0) begin
        emit = 1'b1;
      end else if (seen_inc >= cfg.c) begin
        emit  = 1'b1;
        r_new = VALUE_W'(racc_sh) - VALUE_W'(cfg.u);
      end else if ((seen_inc == cfg.c - CW_W'(1)) && (racc_sh < {1'b0, cfg.u})) begin
        emit  = 1'b1;
        r_new = VALUE_W'(racc_sh);
      end
    end
    if (emit) begin
      in_rem_next = 1'b0;
      q_next      = '0;
      sat_next    = 1'b0;
      racc_next   = '0;
      seen_next   = '0;
    end
  end

  // A closed pending code leaves in any cycle with a free result slot; an open
  // one leaves when a newer code replaces it.
  assign send_needed = p_valid && (p_closed || emit);
  assign step        = busy && (!send_needed || credit_ok);
  assign flush       = !busy && p_valid && p_closed && credit_ok;
  assign send        = step ? send_needed : flush;
  assign send_q      = p_q;
  always_comb begin
    send_code      = p_code;
    send_code.last = p_closed;
  end

  assign byte_take = byte_valid && (!busy || (step && last_bit));

  // Byte shift register.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      sr      <= '0;
      bit_idx <= '0;
    end else begin
      if (step) begin
        sr      <= {sr[CODE_W-2:0], 1'b0};
        bit_idx <= bit_idx - IDX_W'(1);
        if (last_bit) begin
          busy <= 1'b0;
        end
      end
      if (byte_take) begin
        busy    <= 1'b1;
        sr      <= byte_data;
        bit_idx <= IDX_W'(CODE_W - 1);
      end
    end
  end

  // Decode state advances with each step.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_rem <= 1'b0;
      q      <= '0;
      sat    <= 1'b0;
      racc   <= '0;
      seen   <= '0;
    end else if (step) begin
      in_rem <= in_rem_next;
      q      <= q_next;
      sat    <= sat_next;
      racc   <= racc_next;
      seen   <= seen_next;
    end
  end

  // Pending code: replaced on a new code, dropped when sent, closed at the
  // end of its byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid  <= 1'b0;
      p_closed <= 1'b0;
    end else if (step) begin
      if (emit) begin
        p_valid  <= 1'b1;
        p_closed <= last_bit;
      end else if (send) begin
        p_valid  <= 1'b0;
        p_closed <= 1'b0;
      end else if (last_bit && p_valid) begin
        p_closed <= 1'b1;
      end
    end else if (flush) begin
      p_valid  <= 1'b0;
      p_closed <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      p_q         <= q;
      p_code.m    <= cfg.m;
      p_code.r    <= r_new;
      p_code.sat  <= sat;
      p_code.last <= 1'b0;
    end
  end

endmodule : gbd_bit_decoder
`default_nettype wire

FILE: rtl/gbd_value_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbd_value_unit
// Forms quotient times divisor plus remainder in two stages and queues the
// results; slots are reserved when a code is sent so the stages never stall.
// ----------------------------------------------------------------------------
module gbd_value_unit
  import gbd_pkg::*;
#(
  parameter int QUOTIENT_BITS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     send,
  input  wire logic [QUOTIENT_BITS-1:0] send_q,
  input  wire gbd_code_t                send_code,
  output logic                          credit_ok,
  output logic                          empty,
  input  wire logic                     pop,
  output logic [VALUE_W-1:0]            value,
  output logic                          overflow,
  output logic                          last
);

  localparam int PROD_W = QUOTIENT_BITS + DIV_W;
  localparam int PTR_W  = $clog2(OUT_DEPTH);
  localparam int CNT_W  = $clog2(OUT_DEPTH + 1);

  logic [PROD_W-1:0]  prod;
  logic               s1_valid;
  logic [VALUE_W-1:0] s1_prod;
  logic [VALUE_W-1:0] s1_r;
  logic               s1_sat;
  logic               s1_last;

  logic [VALUE_W-1:0] val_mem  [OUT_DEPTH];
  logic               sat_mem  [OUT_DEPTH];
  logic               last_mem [OUT_DEPTH];
  logic [PTR_W-1:0]   wptr;
  logic [PTR_W-1:0]   rptr;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   credits;
  logic               pop_acc;

  // Multiply stage.
  assign prod = {{DIV_W{1'b0}}, send_q} * {{QUOTIENT_BITS{1'b0}}, send_code.m};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= send;
    end
  end

  always_ff @(posedge clk) begin
    s1_prod <= VALUE_W'(prod);
    s1_r    <= send_code.r;
    s1_sat  <= send_code.sat;
    s1_last <= send_code.last;
  end

  // Add stage writes straight into the result queue.
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      val_mem[wptr]  <= s1_prod + s1_r;
      sat_mem[wptr]  <= s1_sat;
      last_mem[wptr] <= s1_last;
    end
  end

  assign empty    = (count == '0);
  assign pop_acc  = pop && !empty;
  assign value    = val_mem[rptr];
  assign overflow = sat_mem[rptr];
  assign last     = last_mem[rptr];

  // Queue pointers, fill count and reserved slots.
  assign credit_ok = (credits < CNT_W'(OUT_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr    <= '0;
      rptr    <= '0;
      count   <= '0;
      credits <= '0;
    end else begin
      if (s1_valid) begin
        wptr <= wptr + PTR_W'(1);
      end
      if (pop_acc) begin
        rptr <= rptr + PTR_W'(1);
      end
      count   <= count + CNT_W'(s1_valid) - CNT_W'(pop_acc);
      credits <= credits + CNT_W'(send) - CNT_W'(pop_acc);
    end
  end

endmodule : gbd_value_unit
`default_nettype wire

FILE: rtl/golomb_bitstream_decoder_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// golomb_bitstream_decoder_top
// Golomb decoder with truncated-binary remainder, byte in, values out.
// ----------------------------------------------------------------------------
// Coded bytes are pushed into a four-entry input queue and decoded one bit
// per cycle, most significant bit first, and bytes follow each other without
// a gap. Each finished code yields one value, q * divisor + r, with overflow
// set when the quotient count saturated and last set on the final value of
// its byte; the last flag of a byte's final value is settled in the cycle
// after that byte's last bit. Values pass through a two-stage multiply and
// add and land in an eight-entry result queue; decoding pauses only while
// all eight result slots are reserved. A beat on the configuration channel
// writes the divisor and should only be sent while the decoder is idle. No
// clearing pass runs after reset.
// ----------------------------------------------------------------------------
module golomb_bitstream_decoder_top
  import gbd_pkg::*;
#(
  parameter int QUOTIENT_BITS = 16,
  parameter int DIVISOR_BITS  = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [CODE_W-1:0] code_byte,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [DIV_W-1:0]  divisor,
  output logic                   empty,
  input  wire logic              pop,
  output logic [VALUE_W-1:0]     value,
  output logic                   overflow,
  output logic                   last
);

  logic                     byte_valid;
  logic [CODE_W-1:0]        byte_data;
  logic                     byte_take;
  gbd_cfg_t                 cfg;
  logic                     credit_ok;
  logic                     send;
  logic [QUOTIENT_BITS-1:0] send_q;
  gbd_code_t                send_code;

  // Input queue and divisor register.
  gbd_front #(
    .DIVISOR_BITS (DIVISOR_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .code_byte  (code_byte),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .divisor    (divisor),
    .byte_valid (byte_valid),
    .byte_data  (byte_data),
    .byte_take  (byte_take),
    .cfg        (cfg)
  );

  // Bit-serial decode.
  gbd_bit_decoder #(
    .QUOTIENT_BITS (QUOTIENT_BITS)
  ) u_decoder (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_data  (byte_data),
    .byte_take  (byte_take),
    .cfg        (cfg),
    .credit_ok  (credit_ok),
    .send       (send),
    .send_q     (send_q),
    .send_code  (send_code)
  );

  // Value arithmetic and result queue.
  gbd_value_unit #(
    .QUOTIENT_BITS (QUOTIENT_BITS)
  ) u_value (
    .clk       (clk),
    .rst       (rst),
    .send      (send),
    .send_q    (send_q),
    .send_code (send_code),
    .credit_ok (credit_ok),
    .empty     (empty),
    .pop       (pop),
    .value     (value),
    .overflow  (overflow),
    .last      (last)
  );

endmodule : golomb_bitstream_decoder_top
`default_nettype wire
